/* rtl/ptlc_pkg.sv */
// Constants, types and the LED path table for the presence trigger LED chaser.
package ptlc_pkg;

   localparam int unsigned HOLD_MS    = 2000;
   localparam int unsigned PATH_LEN   = 16;
   localparam int unsigned FACTOR_MAX = 10;
   localparam int unsigned STEP_UNIT  = HOLD_MS / (3 * PATH_LEN);

   localparam int unsigned CLOCK_W  = 32;
   localparam int unsigned DIST_W   = 11;
   localparam int unsigned DBAND_W  = 8;
   localparam int unsigned STEP_W   = $clog2(PATH_LEN);
   localparam int unsigned LED_W    = 5;
   localparam int unsigned AGE_W    = $clog2(HOLD_MS + 1);
   localparam int unsigned FACTOR_W = $clog2(FACTOR_MAX + 1);
   localparam int unsigned AGE10_W  = $clog2(FACTOR_MAX * HOLD_MS + 1);

   localparam logic [DIST_W-1:0]  DIST_MAX        = DIST_W'(1200);
   localparam logic [DIST_W-1:0]  NEAR_THRESH_RST = DIST_W'(100);
   localparam logic [DBAND_W-1:0] DEADBAND_RST    = DBAND_W'(3);

   // Configuration register indexes
   localparam logic CSR_NEAR_THRESHOLD = 1'b0;
   localparam logic CSR_DEADBAND       = 1'b1;

   typedef enum logic [1:0] {
      COLOUR_RED   = 2'd0,
      COLOUR_GREEN = 2'd1,
      COLOUR_WHITE = 2'd2
   } colour_type;

   typedef struct packed {
      logic [LED_W-1:0] outer;
      logic             present;
      logic [LED_W-1:0] inner;
   } path_led_type;

   // Outer ring LED and optional inner LED for each step of the path.
   function automatic path_led_type path_lookup(input logic [STEP_W-1:0] step);
      path_led_type r;
      r.present = 1'b0;
      r.inner   = '0;
      case (step)
         4'd0:  begin r.outer = 5'd0;  r.present = 1'b1; r.inner = 5'd6;  end
         4'd1:  begin r.outer = 5'd1;  end
         4'd2:  begin r.outer = 5'd2;  r.present = 1'b1; r.inner = 5'd7;  end
         4'd3:  begin r.outer = 5'd3;  end
         4'd4:  begin r.outer = 5'd4;  r.present = 1'b1; r.inner = 5'd8;  end
         4'd5:  begin r.outer = 5'd9;  end
         4'd6:  begin r.outer = 5'd14; r.present = 1'b1; r.inner = 5'd13; end
         4'd7:  begin r.outer = 5'd19; end
         4'd8:  begin r.outer = 5'd24; r.present = 1'b1; r.inner = 5'd18; end
         4'd9:  begin r.outer = 5'd23; end
         4'd10: begin r.outer = 5'd22; r.present = 1'b1; r.inner = 5'd17; end
         4'd11: begin r.outer = 5'd21; end
         4'd12: begin r.outer = 5'd20; r.present = 1'b1; r.inner = 5'd16; end
         4'd13: begin r.outer = 5'd15; end
         4'd14: begin r.outer = 5'd10; r.present = 1'b1; r.inner = 5'd11; end
         4'd15: begin r.outer = 5'd5;  end
         default: begin r.outer = 5'd0; end
      endcase
      return r;
   endfunction

endpackage

/* rtl/presence_trigger_led_chaser_core.sv */
// Top level of the presence trigger LED chaser: trigger tracking, path stepping, result register.
//
// One request item is one polling pass. The block takes an item in every cycle in which
// req_tready is high: the whole pass (clock advance, trigger expiry, distance deadband,
// motion stamp, path step and LED lookup) is one stage of logic between the state
// registers and the result register, and its result appears on rsp_ in the cycle after
// acceptance. The result register acts as the output stage: while a result waits, a
// new item is still taken whenever the consumer takes the waiting one in the same
// cycle. The centre LED 12 is always lit and is not reported.
// Configuration writes are taken at any edge with csr_we high; write them only
// while no pass is in flight.
module presence_trigger_led_chaser_core (
   input  logic        clock,
   input  logic        reset,
   // request: [7:0] ms_elapsed, [8] button_pressed, [19:9] distance_cm,
   // [20] motion_low, [23:21] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // request user: [0] distance_valid
   input  logic        req_tuser,
   // response: [3:0] path_step, [8:4] outer_led, [13:9] inner_led, [15:14] colour,
   // [16] distance_changed, [17] motion_started, [18] near_active,
   // [19] motion_active, [23:20] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // response user: [0] inner_led_present
   output logic        rsp_tuser,
   // configuration write port
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata
);
   import ptlc_pkg::*;

   // configuration
   logic [DIST_W-1:0]  near_thresh_ff;
   logic [DBAND_W-1:0] deadband_ff;

   // pass state
   logic [CLOCK_W-1:0] clock_ms_ff,  clock_ms_in;
   logic [CLOCK_W-1:0] near_stamp_ff, near_stamp_in;
   logic [CLOCK_W-1:0] motion_stamp_ff, motion_stamp_in;
   logic [CLOCK_W-1:0] next_step_ff, next_step_in;
   logic [DIST_W-1:0]  tracked_ff, tracked_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   // result register
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   // unpacked request fields
   logic [7:0]        ms_elapsed;
   logic              button_pressed;
   logic [DIST_W-1:0] distance_cm;
   logic              motion_low;
   logic              distance_valid;

   logic               accept;
   logic [CLOCK_W-1:0] near_exp, motion_exp, newest;
   logic [DIST_W-1:0]  dist_clamped, dist_diff;
   logic               changed, started;
   logic [AGE_W-1:0]   age;
   logic [AGE10_W-1:0] age_x10;
   logic [FACTOR_W-1:0] factor;
   logic [CLOCK_W-1:0] delay;
   colour_type         colour;
   path_led_type       leds;

   assign ms_elapsed     = req_tdata[7:0];
   assign button_pressed = req_tdata[8];
   assign distance_cm    = req_tdata[19:9];
   assign motion_low     = req_tdata[20];
   assign distance_valid = req_tuser;

   // Take a new item when the output stage is empty or drains this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      // advance the free-running clock first
      clock_ms_in = clock_ms_ff + CLOCK_W'(ms_elapsed);

      // button cancels both triggers, then drop stamps older than the hold time
      near_exp   = button_pressed ? '0 : near_stamp_ff;
      motion_exp = button_pressed ? '0 : motion_stamp_ff;
      if ((clock_ms_in - near_exp) > CLOCK_W'(HOLD_MS)) begin
         near_exp = '0;
      end
      if ((clock_ms_in - motion_exp) > CLOCK_W'(HOLD_MS)) begin
         motion_exp = '0;
      end

      // distance sample with deadband; near check uses the tracked value
      dist_clamped  = (distance_cm > DIST_MAX) ? DIST_MAX : distance_cm;
      dist_diff     = (tracked_ff > dist_clamped) ? (tracked_ff - dist_clamped)
                                                  : (dist_clamped - tracked_ff);
      changed       = 1'b0;
      tracked_in    = tracked_ff;
      near_stamp_in = near_exp;
      if (distance_valid) begin
         if (dist_diff > DIST_W'(deadband_ff)) begin
            tracked_in = dist_clamped;
            changed    = 1'b1;
         end
         if (tracked_in < near_thresh_ff) begin
            near_stamp_in = clock_ms_in;
         end
      end

      // motion pin; a stamp taken at clock zero still reads as idle
      started         = motion_low && (motion_exp == '0);
      motion_stamp_in = motion_low ? clock_ms_in : motion_exp;

      // step delay grows with the age of the newest trigger; every active stamp
      // is at most HOLD_MS old, so the low bits of the age are exact
      newest  = (near_stamp_in > motion_stamp_in) ? near_stamp_in : motion_stamp_in;
      age     = AGE_W'(clock_ms_in - newest);
      age_x10 = AGE10_W'(age) * AGE10_W'(FACTOR_MAX);
      factor  = FACTOR_W'(1);
      for (int k = 2; k <= FACTOR_MAX; k++) begin
         if (age_x10 >= AGE10_W'(k * HOLD_MS)) begin
            factor = FACTOR_W'(k);
         end
      end
      delay = CLOCK_W'(STEP_UNIT) * CLOCK_W'(factor);

      step_in      = step_ff;
      next_step_in = next_step_ff;
      if ((near_stamp_in != '0) || (motion_stamp_in != '0)) begin
         if (next_step_ff <= clock_ms_in) begin
            step_in      = step_ff + STEP_W'(1);
            next_step_in = clock_ms_in + delay;
         end
      end

      // colour follows the newer trigger; white when both stamps are equal
      if (near_stamp_in > motion_stamp_in) begin
         colour = COLOUR_RED;
      end else if (motion_stamp_in > near_stamp_in) begin
         colour = COLOUR_GREEN;
      end else begin
         colour = COLOUR_WHITE;
      end

      leds = path_lookup(step_in);

      rsp_data_in        = '0;
      rsp_data_in[3:0]   = step_in;
      rsp_data_in[8:4]   = leds.outer;
      rsp_data_in[13:9]  = leds.inner;
      rsp_data_in[15:14] = colour;
      rsp_data_in[16]    = changed;
      rsp_data_in[17]    = started;
      rsp_data_in[18]    = (near_stamp_in != '0);
      rsp_data_in[19]    = (motion_stamp_in != '0);
      rsp_user_in        = leds.present;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         near_thresh_ff <= NEAR_THRESH_RST;
         deadband_ff    <= DEADBAND_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NEAR_THRESHOLD: near_thresh_ff <= csr_wdata;
            CSR_DEADBAND:       deadband_ff    <= csr_wdata[DBAND_W-1:0];
            default:            near_thresh_ff <= near_thresh_ff;
         endcase
      end
   end

   // pass state: advance only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ms_ff     <= '0;
         near_stamp_ff   <= '0;
         motion_stamp_ff <= '0;
         next_step_ff    <= '0;
         tracked_ff      <= '0;
         step_ff         <= '0;
      end else if (accept) begin
         clock_ms_ff     <= clock_ms_in;
         near_stamp_ff   <= near_stamp_in;
         motion_stamp_ff <= motion_stamp_in;
         next_step_ff    <= next_step_in;
         tracked_ff      <= tracked_in;
         step_ff         <= step_in;
      end
   end

   // output stage: hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
